>>> sv/mmb_pkg.sv
// Shared types, codes and helpers for the matrix multiply block.
package mmb_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int DIM_W     = 4;
  localparam int POS_W     = 3;
  localparam int IDX_W     = 6;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 36;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [POS_W-1:0]         result_row;
    logic [POS_W-1:0]         result_col;
    logic                     last;
    logic                     status;
  } out_item_t;

  // Controls for the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] dmax);
    logic [DIM_W-1:0] v;
    begin
      v = d;
      if (d == '0) v = DIM_W'(1);
      else if (d > dmax) v = dmax;
      return v;
    end
  endfunction

endpackage

>>> sv/mmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmb_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mmb_mac.sv
// Shared multiply-accumulate unit: registered product, floor shift, saturation.
module mmb_mac #(
  parameter int FRAC_BITS = mmb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  mmb_pkg::mac_ctrl_t                ctrl,
  input  logic signed [mmb_pkg::DATA_W-1:0] a,
  input  logic signed [mmb_pkg::DATA_W-1:0] b,
  output logic signed [mmb_pkg::DATA_W-1:0] result
);

  localparam int PW = 2 * mmb_pkg::DATA_W;
  localparam logic signed [PW-1:0] P_MAX = PW'(64'sh7FFF_FFFF);
  localparam logic signed [PW-1:0] P_MIN = -PW'(64'sh8000_0000);
  localparam logic signed [mmb_pkg::ACC_W-1:0] A_MAX = mmb_pkg::ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [mmb_pkg::ACC_W-1:0] A_MIN = -mmb_pkg::ACC_W'(64'sh8000_0000);

  logic signed [PW-1:0]             prod;
  logic signed [PW-1:0]             shifted;
  logic signed [mmb_pkg::DATA_W-1:0] term;
  logic signed [mmb_pkg::ACC_W-1:0]  acc;
  logic signed [mmb_pkg::ACC_W-1:0]  term_ext;

  // An arithmetic right shift drops the low bits, which rounds towards minus infinity.
  assign shifted = prod >>> FRAC_BITS;

  always_comb begin
    if (shifted > P_MAX) term = mmb_pkg::DATA_W'(P_MAX);
    else if (shifted < P_MIN) term = mmb_pkg::DATA_W'(P_MIN);
    else term = shifted[mmb_pkg::DATA_W-1:0];
  end

  assign term_ext = mmb_pkg::ACC_W'(term);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PW'(a) * PW'(b);
    end
    if (ctrl.acc_en) begin
      acc <= ctrl.acc_first ? term_ext : acc + term_ext;
    end
  end

  always_comb begin
    if (acc > A_MAX) result = mmb_pkg::DATA_W'(A_MAX);
    else if (acc < A_MIN) result = mmb_pkg::DATA_W'(A_MIN);
    else result = acc[mmb_pkg::DATA_W-1:0];
  end

endmodule

>>> sv/matrix_multiply_broadcast.sv
// Top level of the matrix multiply block with scalar broadcast and elementwise mode.
//
// Elements of A and B are loaded with op 0 and op 1, one request per cycle, into two
// RAMs; an entry must be written before a start reads it. A start request computes C
// on one shared multiply-accumulate unit and emits it row by row, last set on the
// final element; incompatible shapes give a single result with status set. Each
// multiply-accumulate step passes through the RAM read, multiply and accumulate
// states, with K steps for an element of C, K being cols_a for a matrix product and 1
// otherwise; an element waits in the emit state while the output is stalled. No
// request is taken while a start is being worked on; the output register lets a
// load be taken while the final result still waits.
module matrix_multiply_broadcast #(
  parameter int MAX_DIM   = mmb_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = mmb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mmb_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mmb_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmb_pkg::DIM_W-1:0]           cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [mmb_pkg::DIM_W-1:0] DIM_MAX = mmb_pkg::DIM_W'(MAX_DIM);
  localparam logic [mmb_pkg::DIM_W-1:0] ONE     = mmb_pkg::DIM_W'(1);

  typedef enum logic [2:0] {S_IDLE, S_ADDR, S_MUL, S_ACC, S_EMIT, S_ERR} state_t;
  typedef enum logic [2:0] {M_SCALAR_A, M_SCALAR_B, M_MATMUL, M_HADAMARD, M_ERROR} mode_t;

  state_t state;
  mode_t  mode, mode_next;

  logic [mmb_pkg::DIM_W-1:0] rows_a, cols_a, rows_b, cols_b;
  logic [mmb_pkg::DIM_W-1:0] ra, ca, rb, cb;
  logic [mmb_pkg::DIM_W-1:0] n_rows, n_cols, n_k, stride_a, stride_b;
  logic [mmb_pkg::DIM_W-1:0] n_rows_next, n_cols_next, n_k_next;
  logic [mmb_pkg::POS_W-1:0] r, c, k;

  logic        in_acc, out_free, k_done, elem_last;
  logic [7:0]  a_lin, b_lin;
  logic        we_a, we_b;
  logic [ADDR_W-1:0] waddr, a_addr, b_addr;
  logic signed [mmb_pkg::DATA_W-1:0] a_data, b_data, mac_result;
  mmb_pkg::mac_ctrl_t mac_ctrl;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= ONE;
      cols_a <= ONE;
      rows_b <= ONE;
      cols_b <= ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        mmb_pkg::REG_ROWS_A: rows_a <= cfg_data;
        mmb_pkg::REG_COLS_A: cols_a <= cfg_data;
        mmb_pkg::REG_ROWS_B: rows_b <= cfg_data;
        mmb_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ra = mmb_pkg::clamp_dim(rows_a, DIM_MAX);
  assign ca = mmb_pkg::clamp_dim(cols_a, DIM_MAX);
  assign rb = mmb_pkg::clamp_dim(rows_b, DIM_MAX);
  assign cb = mmb_pkg::clamp_dim(cols_b, DIM_MAX);

  // Mode selection follows the priority: scalar A, scalar B, product, elementwise.
  always_comb begin
    mode_next   = M_ERROR;
    n_rows_next = ONE;
    n_cols_next = ONE;
    n_k_next    = ONE;
    if (ra == ONE && ca == ONE) begin
      mode_next   = M_SCALAR_A;
      n_rows_next = rb;
      n_cols_next = cb;
    end else if (rb == ONE && cb == ONE) begin
      mode_next   = M_SCALAR_B;
      n_rows_next = ra;
      n_cols_next = ca;
    end else if (ca == rb) begin
      mode_next   = M_MATMUL;
      n_rows_next = ra;
      n_cols_next = cb;
      n_k_next    = ca;
    end else if (ca == cb && ra == rb) begin
      mode_next   = M_HADAMARD;
      n_rows_next = ra;
      n_cols_next = ca;
    end
  end

  // Row-major addresses of the operands for the current step.
  always_comb begin
    a_lin = '0;
    b_lin = '0;
    case (mode)
      M_SCALAR_A: b_lin = 8'({5'd0, r} * {4'd0, stride_b}) + 8'(c);
      M_SCALAR_B: a_lin = 8'({5'd0, r} * {4'd0, stride_a}) + 8'(c);
      M_MATMUL: begin
        a_lin = 8'({5'd0, r} * {4'd0, stride_a}) + 8'(k);
        b_lin = 8'({5'd0, k} * {4'd0, stride_b}) + 8'(c);
      end
      M_HADAMARD: begin
        a_lin = 8'({5'd0, r} * {4'd0, stride_a}) + 8'(c);
        b_lin = a_lin;
      end
      default: ;
    endcase
  end

  assign a_addr = a_lin[ADDR_W-1:0];
  assign b_addr = b_lin[ADDR_W-1:0];

  assign waddr = in_data.elem_index[ADDR_W-1:0];
  assign we_a  = in_acc && in_data.op == mmb_pkg::OP_LOAD_A
                 && 7'(in_data.elem_index) < 7'(DEPTH);
  assign we_b  = in_acc && in_data.op == mmb_pkg::OP_LOAD_B
                 && 7'(in_data.elem_index) < 7'(DEPTH);

  mmb_ram #(.WIDTH(mmb_pkg::DATA_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(in_data.elem_value),
    .raddr(a_addr),
    .rdata(a_data)
  );

  mmb_ram #(.WIDTH(mmb_pkg::DATA_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(in_data.elem_value),
    .raddr(b_addr),
    .rdata(b_data)
  );

  assign mac_ctrl.mul_en    = (state == S_MUL);
  assign mac_ctrl.acc_en    = (state == S_ACC);
  assign mac_ctrl.acc_first = (k == '0);

  mmb_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .a     (a_data),
    .b     (b_data),
    .result(mac_result)
  );

  assign k_done    = ({1'b0, k} == n_k - ONE);
  assign elem_last = ({1'b0, r} == n_rows - ONE) && ({1'b0, c} == n_cols - ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= M_ERROR;
      out_valid <= 1'b0;
      r         <= '0;
      c         <= '0;
      k         <= '0;
    end else begin
      // In the emitting states a free output is refilled below instead of emptied.
      if (out_valid && !out_stall && state != S_EMIT && state != S_ERR) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_data.op == mmb_pkg::OP_START) begin
            mode     <= mode_next;
            n_rows   <= n_rows_next;
            n_cols   <= n_cols_next;
            n_k      <= n_k_next;
            stride_a <= ca;
            stride_b <= cb;
            r        <= '0;
            c        <= '0;
            k        <= '0;
            state    <= (mode_next == M_ERROR) ? S_ERR : S_ADDR;
          end
        end
        S_ADDR: state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          if (k_done) begin
            state <= S_EMIT;
          end else begin
            k     <= k + 1'b1;
            state <= S_ADDR;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.result_value <= mac_result;
            out_data.result_row   <= r;
            out_data.result_col   <= c;
            out_data.last         <= elem_last;
            out_data.status       <= 1'b0;
            k                     <= '0;
            if (elem_last) begin
              state <= S_IDLE;
            end else begin
              if ({1'b0, c} == n_cols - ONE) begin
                c <= '0;
                r <= r + 1'b1;
              end else begin
                c <= c + 1'b1;
              end
              state <= S_ADDR;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.result_value <= '0;
            out_data.result_row   <= '0;
            out_data.result_col   <= '0;
            out_data.last         <= 1'b1;
            out_data.status       <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/mmb_checker.sv
// Port-level checks for the matrix multiply block, bound to the top level.
module mmb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input mmb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mmb_pkg::out_item_t out_data
);

  // A result that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An error result is always the final one of its start request.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.last)
    else $error("error result without last");

  // An error result carries zeros in value and position.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.result_value == '0
      && out_data.result_row == '0 && out_data.result_col == '0)
    else $error("error result with non-zero payload");

  // Once a start request is taken the block is busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == mmb_pkg::OP_START |=> in_stall)
    else $error("request taken straight after a start");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown after reset");

endmodule

bind matrix_multiply_broadcast mmb_checker u_mmb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

>>> sim/matrix_multiply_broadcast_checker.sv
// Result predictor and comparator for the matrix multiply block, watching both channels.
module matrix_multiply_broadcast_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  mmb_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mmb_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmb_pkg::DIM_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            c_outstanding
);
  import mmb_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;

  logic [DATA_W-1:0] a_words [STORE_DEPTH];
  logic [DATA_W-1:0] b_words [STORE_DEPTH];
  logic [DIM_W-1:0]  rows_a, cols_a, rows_b, cols_b;
  out_item_t         expected_c [$];

  initial begin
    mismatches = 0;
    c_outstanding = 0;
  end

  function automatic int shape_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(raw);
  endfunction

  function automatic logic signed [DATA_W-1:0] saturate(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // The exact product is floored by the arithmetic shift, then clipped to 32 bits.
  function automatic logic signed [DATA_W-1:0] fixed_product(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] y
  );
    logic signed [63:0] xw, yw, p;
    xw = x;
    yw = y;
    p = xw * yw;
    return saturate(p >>> FRAC_BITS_DEF);
  endfunction

  task automatic push_result(input logic signed [DATA_W-1:0] v, input int r, input int c,
                             input bit last_flag, input bit error_flag);
    out_item_t e;
    e.result_value = v;
    e.result_row = r[POS_W-1:0];
    e.result_col = c[POS_W-1:0];
    e.last = last_flag;
    e.status = error_flag;
    expected_c.push_back(e);
  endtask

  task automatic predict_c();
    int ra, ca, rb, cb, r, c, k;
    logic signed [63:0] acc;
    ra = shape_dim(rows_a);
    ca = shape_dim(cols_a);
    rb = shape_dim(rows_b);
    cb = shape_dim(cols_b);
    if (ra == 1 && ca == 1) begin
      for (r = 0; r < rb; r++)
        for (c = 0; c < cb; c++)
          push_result(fixed_product(a_words[0], b_words[r * cb + c]), r, c,
                      r == rb - 1 && c == cb - 1, 1'b0);
    end else if (rb == 1 && cb == 1) begin
      for (r = 0; r < ra; r++)
        for (c = 0; c < ca; c++)
          push_result(fixed_product(a_words[r * ca + c], b_words[0]), r, c,
                      r == ra - 1 && c == ca - 1, 1'b0);
    end else if (ca == rb) begin
      // Clipped products are summed exactly; only the finished sum is clipped.
      for (r = 0; r < ra; r++)
        for (c = 0; c < cb; c++) begin
          acc = '0;
          for (k = 0; k < ca; k++)
            acc = acc + fixed_product(a_words[r * ca + k], b_words[k * cb + c]);
          push_result(saturate(acc), r, c, r == ra - 1 && c == cb - 1, 1'b0);
        end
    end else if (ca == cb && ra == rb) begin
      for (r = 0; r < ra; r++)
        for (c = 0; c < ca; c++)
          push_result(fixed_product(a_words[r * ca + c], b_words[r * ca + c]), r, c,
                      r == ra - 1 && c == ca - 1, 1'b0);
    end else begin
      push_result('0, 0, 0, 1'b1, 1'b1);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_c.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing expected", got));
    end else begin
      want = expected_c.pop_front();
      if (got.result_value !== want.result_value)
        report_mismatch($sformatf("C[%0d][%0d] value %h, expected %h", want.result_row,
                                  want.result_col, got.result_value, want.result_value));
      if (got.result_row !== want.result_row)
        report_mismatch($sformatf("row %0d, expected %0d", got.result_row, want.result_row));
      if (got.result_col !== want.result_col)
        report_mismatch($sformatf("column %0d, expected %0d", got.result_col, want.result_col));
      if (got.last !== want.last)
        report_mismatch($sformatf("C[%0d][%0d] last %b, expected %b", want.result_row,
                                  want.result_col, got.last, want.last));
      if (got.status !== want.status)
        report_mismatch($sformatf("C[%0d][%0d] status %b, expected %b", want.result_row,
                                  want.result_col, got.status, want.status));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_a = 1;
      cols_a = 1;
      rows_b = 1;
      cols_b = 1;
      expected_c.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) begin
        case (in_data.op)
          OP_LOAD_A: a_words[in_data.elem_index] = in_data.elem_value;
          OP_LOAD_B: b_words[in_data.elem_index] = in_data.elem_value;
          OP_START:  predict_c();
          default: ;  // the spare op code is dropped without effect
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A: rows_a = cfg_data;
          REG_COLS_A: cols_a = cfg_data;
          REG_ROWS_B: rows_b = cfg_data;
          REG_COLS_B: cols_b = cfg_data;
          default: ;
        endcase
      end
    end
    c_outstanding = expected_c.size();
  end

endmodule

>>> sim/matrix_multiply_broadcast_tb.sv
// Testbench top: drives loads, starts and shape settings into the block and gives the verdict.
module matrix_multiply_broadcast_tb;
  import mmb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS  = 270;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 5000000;

  typedef enum int {RX_FREE, RX_RANDOM, RX_ALTERNATE, RX_LONG} rx_pattern_e;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  int                   mismatches;
  int                   c_outstanding;

  bit          a_written [MAX_DIM_DEF * MAX_DIM_DEF];
  bit          b_written [MAX_DIM_DEF * MAX_DIM_DEF];
  int          act_ra = 1, act_ca = 1, act_rb = 1, act_cb = 1;
  int          request_count = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  rx_pattern_e rx_pattern = RX_FREE;
  int          rx_left = 0;
  int          hold_left = 0;
  bit          hold_high = 1'b0;

  matrix_multiply_broadcast DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  matrix_multiply_broadcast_checker result_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .mismatches, .c_outstanding
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver moves between free running, random, alternating and long stalls.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    case (rx_pattern)
      RX_FREE:      out_stall <= 1'b0;
      RX_RANDOM:    out_stall <= ($urandom_range(0, 2) == 0);
      RX_ALTERNATE: out_stall <= ~out_stall;
      default: begin
        if (hold_left == 0) begin
          hold_high = ~hold_high;
          hold_left = hold_high ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        hold_left--;
        out_stall <= hold_high;
      end
    endcase
  end

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom();
      3, 4, 5: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      6: begin
        case ($urandom_range(0, 5))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0001;
          4: v = 32'h0001_0000;
          default: v = '0;
        endcase
      end
      default: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 15);
    if (r < 11) return $urandom_range(1, 3);
    if (r < 14) return $urandom_range(4, 7);
    return MAX_DIM_DEF;
  endfunction

  function automatic logic [DIM_W-1:0] raw_dim(input int d);
    // Out-of-range register values stand in for the extreme sizes now and then.
    if (d == 1 && $urandom_range(0, 3) == 0) return '0;
    if (d == MAX_DIM_DEF && $urandom_range(0, 1) == 0)
      return DIM_W'($urandom_range(MAX_DIM_DEF + 1, 15));
    return DIM_W'(d);
  endfunction

  function automatic int active_dim(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(raw);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input int idx,
                              input logic [DATA_W-1:0] value);
    in_item_t item;
    item.op = op;
    item.elem_index = idx[IDX_W-1:0];
    item.elem_value = value;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (op == OP_LOAD_A) a_written[idx] = 1'b1;
    if (op == OP_LOAD_B) b_written[idx] = 1'b1;
    if (op != OP_UNUSED) request_count++;
  endtask

  // Loads each element the current shapes use that is not yet written; a fresh pass rewrites them all.
  task automatic load_operands(input bit fresh);
    for (int i = 0; i < act_ra * act_ca; i++)
      if (fresh || !a_written[i]) send_request(OP_LOAD_A, i, pick_value());
    for (int i = 0; i < act_rb * act_cb; i++)
      if (fresh || !b_written[i]) send_request(OP_LOAD_B, i, pick_value());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (c_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_shape(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                           input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
    wait_idle();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_COLS_A, ca);
    write_reg(REG_ROWS_B, rb);
    write_reg(REG_COLS_B, cb);
    act_ra = active_dim(ra);
    act_ca = active_dim(ca);
    act_rb = active_dim(rb);
    act_cb = active_dim(cb);
  endtask

  initial begin
    int ra, ca, rb, cb, random_goal;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ROWS_A;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Scalar products at the extremes of the value range, all saturating.
    send_request(OP_LOAD_A, 0, 32'h7FFF_FFFF);
    send_request(OP_LOAD_B, 0, 32'h7FFF_FFFF);
    send_request(OP_START, 63, $urandom());
    send_request(OP_LOAD_A, 0, 32'h8000_0000);
    send_request(OP_START, 0, 32'h8000_0000);
    send_request(OP_LOAD_B, 0, 32'h8000_0000);
    send_request(OP_START, $urandom_range(0, 63), $urandom());
    send_request(OP_UNUSED, $urandom_range(0, 63), $urandom());
    send_request(OP_LOAD_A, 63, 32'hFFFF_FFFF);
    send_request(OP_LOAD_B, 63, 32'h0000_0001);

    // Zero-sized A is taken as a scalar.
    set_shape(4'd0, 4'd0, 4'd2, 4'd3);
    load_operands(1'b0);
    send_request(OP_START, $urandom_range(0, 63), $urandom());

    // Oversized A times a scalar of one LSB, so a negative product rounds down to -1.
    set_shape(4'd15, 4'd1, 4'd1, 4'd0);
    send_request(OP_LOAD_B, 0, 32'h0000_0001);
    send_request(OP_LOAD_A, 1, 32'hFFFF_FFFF);
    load_operands(1'b0);
    send_request(OP_START, $urandom_range(0, 63), $urandom());

    set_shape(4'd2, 4'd3, 4'd3, 4'd2);
    send_request(OP_START, $urandom_range(0, 63), $urandom());
    set_shape(4'd2, 4'd3, 4'd2, 4'd3);
    send_request(OP_START, $urandom_range(0, 63), $urandom());
    set_shape(4'd2, 4'd3, 4'd2, 4'd2);
    send_request(OP_START, $urandom_range(0, 63), $urandom());

    random_goal = request_count + RANDOM_ITEMS;
    while (request_count < random_goal) begin
      case ($urandom_range(0, 4))
        0: begin ra = 1; ca = 1; rb = pick_dim(); cb = pick_dim(); end
        1: begin ra = pick_dim(); ca = pick_dim(); rb = 1; cb = 1; end
        2: begin ra = pick_dim(); ca = pick_dim(); rb = ca; cb = pick_dim(); end
        3: begin ra = pick_dim(); ca = pick_dim(); rb = ra; cb = ca; end
        default: begin ra = pick_dim(); ca = pick_dim(); rb = pick_dim(); cb = pick_dim(); end
      endcase
      set_shape(raw_dim(ra), raw_dim(ca), raw_dim(rb), raw_dim(cb));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          7, 8: begin
            // Stray loads anywhere in the stores, mixed with the spare op code.
            repeat ($urandom_range(1, 6)) begin
              case ($urandom_range(0, 2))
                0: send_request(OP_LOAD_A, $urandom_range(0, 63), pick_value());
                1: send_request(OP_LOAD_B, $urandom_range(0, 63), pick_value());
                default: send_request(OP_UNUSED, $urandom_range(0, 63), $urandom());
              endcase
            end
            load_operands(1'b0);
          end
          9: load_operands(1'b0);
          default: load_operands(1'b1);
        endcase
        send_request(OP_START, $urandom_range(0, 63), $urandom());
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
